/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");

`endif

/* rtl/core/i2cmw_pkg.sv */
package i2cmw_pkg;

   // Command kinds carried on the request tuser bit.
   localparam logic CmdStart = 1'b0;
   localparam logic CmdEvent = 1'b1;

   // Bit counts handed to the serial shift unit.
   localparam logic [3:0] BitsNone = 4'd0;
   localparam logic [3:0] BitsAck  = 4'd1;
   localparam logic [3:0] BitsByte = 4'd8;

   // Shift values for the stop sequence: pull SDA low, then release it.
   localparam logic [7:0] StopLowValue  = 8'h00;
   localparam logic [7:0] ReleaseValue  = 8'hFF;

   localparam int ReqDataW = 24;
   localparam int RspDataW = 24;

   // Request fields; the last member sits in the lowest bits.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       received_bit;
      logic [7:0] byte_total;
      logic [6:0] slave_address;
      logic       cmd;
   } req_item_type;

   // Result fields, packed so that shift_value is in the lowest bits.
   typedef struct packed {
      logic       bad_command;
      logic       done_res;
      logic       nack_seen;
      logic       byte_taken;
      logic       latch_open;
      logic       sda_drive;
      logic [3:0] bit_count;
      logic       shift_load;
      logic [7:0] shift_value;
   } rsp_item_type;

   localparam int RspItemW = $bits(rsp_item_type);

endpackage

/* rtl/core/i2cmw_seq.sv */
`include "assert_macros.svh"

module i2cmw_seq import i2cmw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type rsp
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ADDR_RX  = 3'd1,
      PH_ADDR_CHK = 3'd2,
      PH_DATA_RX  = 3'd3,
      PH_DATA_CHK = 3'd4,
      PH_STOP     = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] bytes_sent_ff, bytes_sent_in;
   logic [7:0] bytes_wanted_ff, bytes_wanted_in;

   always_comb begin
      rsp             = '0;
      phase_in        = phase_ff;
      bytes_sent_in   = bytes_sent_ff;
      bytes_wanted_in = bytes_wanted_ff;

      if (item.cmd == CmdStart) begin
         if (phase_ff != PH_IDLE) begin
            rsp.bad_command = 1'b1;
         end else begin
            // Address with the write bit low, start condition through the latch.
            bytes_wanted_in = item.byte_total;
            bytes_sent_in   = 8'd0;
            rsp.shift_value = {item.slave_address, 1'b0};
            rsp.shift_load  = 1'b1;
            rsp.bit_count   = BitsByte;
            rsp.latch_open  = 1'b1;
            phase_in        = PH_ADDR_RX;
         end
      end else begin
         case (phase_ff)
            PH_ADDR_RX, PH_DATA_RX: begin
               rsp.bit_count = BitsAck;
               phase_in      = (phase_ff == PH_ADDR_RX) ? PH_ADDR_CHK : PH_DATA_CHK;
            end
            PH_ADDR_CHK, PH_DATA_CHK: begin
               if (item.received_bit || (phase_ff == PH_DATA_CHK &&
                                         bytes_sent_ff >= bytes_wanted_ff)) begin
                  rsp.nack_seen   = item.received_bit;
                  rsp.shift_value = StopLowValue;
                  rsp.shift_load  = 1'b1;
                  rsp.bit_count   = BitsAck;
                  phase_in        = PH_STOP;
               end else begin
                  rsp.shift_value = item.tx_byte;
                  rsp.shift_load  = 1'b1;
                  rsp.bit_count   = BitsByte;
                  rsp.byte_taken  = 1'b1;
                  bytes_sent_in   = bytes_sent_ff + 8'd1;
                  phase_in        = PH_DATA_RX;
               end
            end
            PH_STOP: begin
               rsp.shift_value = ReleaseValue;
               rsp.shift_load  = 1'b1;
               rsp.bit_count   = BitsNone;
               rsp.latch_open  = 1'b1;
               rsp.done_res    = 1'b1;
               phase_in        = PH_IDLE;
            end
            default: begin
               rsp.bad_command = 1'b1;
            end
         endcase
      end

      rsp.sda_drive = (phase_in inside {PH_ADDR_RX, PH_DATA_RX, PH_STOP});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bytes_sent_ff   <= 8'd0;
         bytes_wanted_ff <= 8'd0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         bytes_sent_ff   <= bytes_sent_in;
         bytes_wanted_ff <= bytes_wanted_in;
      end
   end

   `ASSERT_NEXT(a_done_goes_idle, clock, reset, fire && rsp.done_res, phase_ff == PH_IDLE)
   `ASSERT_NEXT(a_start_goes_addr, clock, reset,
                fire && rsp.latch_open && !rsp.done_res, phase_ff == PH_ADDR_RX)
   `ASSERT_IMPLIES(a_sent_bounded, clock, reset, phase_ff != PH_IDLE,
                   bytes_sent_ff <= bytes_wanted_ff || bytes_sent_ff == 8'd1)

endmodule

/* rtl/core/i2c_master_write_sequencer.sv */
// An accepted item is held in the input register; its result is registered into the
// result register once that is free or being drained. Throughput: one item per cycle
// while the receiver takes results. When both registers are full, req_tready follows
// rsp_tready in the same cycle, so a stalled receiver holds the sender after two items.
// Reset: synchronous, active high; clears the valid flags and returns the sequencer to idle
// with zero byte counts.
`include "assert_macros.svh"

module i2c_master_write_sequencer import i2cmw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // Fields from bit 0: slave_address[6:0], byte_total[14:7], received_bit[15],
   // tx_byte[23:16].
   input  logic [ReqDataW-1:0] req_tdata,
   // Field: cmd (0 = start write transfer, 1 = shift-done event).
   input  logic                req_tuser,
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // Fields from bit 0: shift_value[7:0], shift_load[8], bit_count[12:9], sda_drive[13],
   // latch_open[14], byte_taken[15], nack_seen[16], done_res[17], bad_command[18],
   // zero fill above.
   output logic [RspDataW-1:0] rsp_tdata
);

   // The input register holds one accepted item; the sequencer processes it
   // when the item moves into the result register.
   logic         in_valid_ff;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type step_rsp;
   logic         move;

   // An item moves forward whenever the result register is empty or being drained.
   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;

   always_comb begin
      in_item_in.cmd           = req_tuser;
      in_item_in.slave_address = req_tdata[6:0];
      in_item_in.byte_total    = req_tdata[14:7];
      in_item_in.received_bit  = req_tdata[15];
      in_item_in.tx_byte       = req_tdata[23:16];
   end

   // The phase and byte counters advance exactly once per item, on the move.
   i2cmw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .fire  (move),
      .item  (in_item_ff),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= in_item_in;
      end
      if (move) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW - RspItemW){1'b0}}, out_item_ff};

   `ASSERT_NEXT(a_move_fills_output, clock, reset, move, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !in_valid_ff, req_tready)

endmodule
